// ===== design/srr_pkg.sv =====
// ============================================================================
// srr_pkg - selective repeat reorder receiver package
// Shared constants, codes and types for the reorder receiver and its parts.
// ============================================================================
package srr_pkg;

    // Reorder window depth and slot index width
    localparam int WINDOW = 32;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Result kind codes
    typedef enum logic {
        KIND_ACK   = 1'b0,
        KIND_DELIV = 1'b1
    } t_kind;

    // Classification of an arriving packet
    typedef enum logic [2:0] {
        OC_INORDER = 3'd0,
        OC_STORED  = 3'd1,
        OC_DUP     = 3'd2,
        OC_STALE   = 3'd3,
        OC_BEYOND  = 3'd4
    } t_outcome;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CLASS = 3'd1,
        S_ACK   = 3'd2,
        S_DELIV = 3'd3,
        S_HELD  = 3'd4
    } t_state;

    // Shared adder request and response
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] diff;
        logic        carry;
    } t_alu_rsp;

endpackage

// ===== design/srr_if.sv =====
// ============================================================================
// srr_if - reorder receiver channel interfaces
// Valid/ready channels for arriving packets and for result items.
// ============================================================================
interface srr_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_num;
    logic [31:0] payload;
    logic        final_flag;

    modport source (output valid, seq_num, payload, final_flag, input ready);
    modport sink   (input valid, seq_num, payload, final_flag, output ready);
endinterface

interface srr_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic        out_final;
    logic [2:0]  outcome;
    logic        last;

    modport source (output valid, kind, out_seq, out_payload, out_final, outcome, last,
                    input ready);
    modport sink   (input valid, kind, out_seq, out_payload, out_final, outcome, last,
                    output ready);
endinterface

// ===== design/srr_alu.sv =====
// ============================================================================
// srr_alu - shared 32-bit add/subtract unit
// Computes a - b (with carry as not-borrow) or a + b for the sequencer.
// ============================================================================
module srr_alu (
    input  srr_pkg::t_alu_req i_req,
    output srr_pkg::t_alu_rsp o_rsp
);

    logic [31:0] b_eff;
    logic [32:0] sum;

    // Invert b and inject carry for subtraction
    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign sum   = {1'b0, i_req.a} + {1'b0, b_eff} + {32'd0, i_req.sub};

    assign o_rsp.diff  = sum[31:0];
    assign o_rsp.carry = sum[32];

endmodule

// ===== design/selective_repeat_reorder_receiver.sv =====
// ============================================================================
// selective_repeat_reorder_receiver - selective repeat ARQ receiver
// Acknowledges each packet, holds early packets in a reorder buffer and
// delivers packets in sequence order.
// ============================================================================
//
//  Channel  Dir  Fields                                             Transfer
//  i_pkt    in   seq_num, payload, final_flag                       valid & ready
//  o_res    out  kind, out_seq, out_payload, out_final, outcome,   valid & ready
//                last
//
//  Steps: a packet is taken in S_IDLE, classified in S_CLASS, and its
//  acknowledgment is loaded in S_ACK, where an out-of-order packet ends.
//  An in-order packet adds a delivery for itself and for each held successor,
//  in S_DELIV and then S_HELD, paced by the shared adder that classifies
//  and then advances the expected number once per delivery. Reset clears
//  the sequencer, the expected number and all slot valid marks. A stalled
//  result register holds the sequencer in the acknowledge and delivery states.
//
module selective_repeat_reorder_receiver (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srr_pkt_if.sink         i_pkt,
    srr_res_if.source       o_res
);

    localparam int WINDOW = srr_pkg::WINDOW;
    localparam int IDX_W  = srr_pkg::IDX_W;
    localparam int SUM_W  = IDX_W + 1;

    // Sequencer and working registers
    srr_pkg::t_state   r_state, n_state;
    srr_pkg::t_outcome r_oc, n_oc;
    logic [31:0]       r_seq;
    logic [31:0]       r_pay;
    logic              r_fin;
    logic [31:0]       r_exp;
    logic [IDX_W-1:0]  r_exp_idx;
    logic [WINDOW-1:0] r_valid;

    // Reorder memory and its registered read
    logic [32:0]       r_slot_mem [WINDOW];
    logic [31:0]       r_rd_pay;
    logic              r_rd_fin;

    // Result register
    logic              r_out_valid;
    srr_pkg::t_kind    r_out_kind;
    logic [31:0]       r_out_seq;
    logic [31:0]       r_out_pay;
    logic              r_out_fin;
    srr_pkg::t_outcome r_out_oc;
    logic              r_out_last;

    // Shared adder
    srr_pkg::t_alu_req alu_req;
    srr_pkg::t_alu_rsp alu_rsp;

    // Control strobes
    logic              can_load;
    logic              ld;
    srr_pkg::t_kind    ld_kind;
    logic [31:0]       ld_seq;
    logic [31:0]       ld_pay;
    logic              ld_fin;
    srr_pkg::t_outcome ld_oc;
    logic              ld_last;
    logic              exp_adv;
    logic              clr_cur;
    logic              rd_en;
    logic              mem_we;

    // Slot indexes
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  nidx;
    logic [SUM_W-1:0]  st_sum;
    logic [IDX_W-1:0]  st_idx;

    srr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign can_load    = !r_out_valid || o_res.ready;
    assign i_pkt.ready = (r_state == srr_pkg::S_IDLE);

    // Index of the slot after the expected one; the number wraps to slot zero
    assign idx_inc = (r_exp_idx == IDX_W'(WINDOW - 1)) ? '0 : r_exp_idx + IDX_W'(1);
    assign nidx    = (r_exp == '1) ? '0 : idx_inc;

    // Slot of an in-window packet: expected slot plus offset, reduced once
    assign st_sum = {1'b0, r_exp_idx} + {1'b0, alu_rsp.diff[IDX_W-1:0]};
    assign st_idx = (st_sum >= SUM_W'(WINDOW)) ? IDX_W'(st_sum - SUM_W'(WINDOW))
                                               : st_sum[IDX_W-1:0];

    // Sequence classification, acknowledgment and delivery
    always_comb begin
        n_state = r_state;
        n_oc    = r_oc;
        alu_req = '{a: r_seq, b: r_exp, sub: 1'b1};
        ld      = 1'b0;
        ld_kind = srr_pkg::KIND_ACK;
        ld_seq  = r_seq;
        ld_pay  = '0;
        ld_fin  = 1'b0;
        ld_oc   = r_oc;
        ld_last = 1'b0;
        exp_adv = 1'b0;
        clr_cur = 1'b0;
        rd_en   = 1'b0;
        mem_we  = 1'b0;
        unique case (r_state)
            srr_pkg::S_IDLE: begin
                if (i_pkt.valid) begin
                    n_state = srr_pkg::S_CLASS;
                end
            end
            srr_pkg::S_CLASS: begin
                if (!alu_rsp.carry) begin
                    n_oc = srr_pkg::OC_STALE;
                end else if (alu_rsp.diff == '0) begin
                    n_oc = srr_pkg::OC_INORDER;
                end else if (alu_rsp.diff >= 32'(WINDOW)) begin
                    n_oc = srr_pkg::OC_BEYOND;
                end else if (r_valid[st_idx]) begin
                    n_oc = srr_pkg::OC_DUP;
                end else begin
                    n_oc   = srr_pkg::OC_STORED;
                    mem_we = 1'b1;
                end
                n_state = srr_pkg::S_ACK;
            end
            srr_pkg::S_ACK: begin
                if (can_load) begin
                    ld      = 1'b1;
                    ld_last = (r_oc != srr_pkg::OC_INORDER);
                    n_state = (r_oc == srr_pkg::OC_INORDER) ? srr_pkg::S_DELIV
                                                            : srr_pkg::S_IDLE;
                end
            end
            srr_pkg::S_DELIV: begin
                alu_req = '{a: r_exp, b: 32'd1, sub: 1'b0};
                if (can_load) begin
                    ld      = 1'b1;
                    ld_kind = srr_pkg::KIND_DELIV;
                    ld_pay  = r_pay;
                    ld_fin  = r_fin;
                    ld_oc   = srr_pkg::OC_INORDER;
                    ld_last = !r_valid[nidx];
                    exp_adv = 1'b1;
                    rd_en   = 1'b1;
                    n_state = r_valid[nidx] ? srr_pkg::S_HELD : srr_pkg::S_IDLE;
                end
            end
            srr_pkg::S_HELD: begin
                alu_req = '{a: r_exp, b: 32'd1, sub: 1'b0};
                if (can_load) begin
                    ld      = 1'b1;
                    ld_kind = srr_pkg::KIND_DELIV;
                    ld_seq  = r_exp;
                    ld_pay  = r_rd_pay;
                    ld_fin  = r_rd_fin;
                    ld_oc   = srr_pkg::OC_INORDER;
                    ld_last = !r_valid[nidx];
                    exp_adv = 1'b1;
                    clr_cur = 1'b1;
                    rd_en   = 1'b1;
                    n_state = r_valid[nidx] ? srr_pkg::S_HELD : srr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srr_pkg::S_IDLE;
            end
        endcase
    end

    // Hold state, expected number and valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srr_pkg::S_IDLE;
            r_oc      <= srr_pkg::OC_INORDER;
            r_exp     <= '0;
            r_exp_idx <= '0;
            r_valid   <= '0;
        end else begin
            r_state <= n_state;
            r_oc    <= n_oc;
            if (exp_adv) begin
                r_exp     <= alu_rsp.diff;
                r_exp_idx <= nidx;
            end
            if (mem_we) begin
                r_valid[st_idx] <= 1'b1;
            end
            if (clr_cur) begin
                r_valid[r_exp_idx] <= 1'b0;
            end
        end
    end

    // Capture the arriving packet on transfer
    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_seq <= i_pkt.seq_num;
            r_pay <= i_pkt.payload;
            r_fin <= i_pkt.final_flag;
        end
    end

    // Write held packets and read the next one ahead of its delivery
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[st_idx] <= {r_fin, r_pay};
        end
        if (rd_en) begin
            {r_rd_fin, r_rd_pay} <= r_slot_mem[nidx];
        end
    end

    // Result register: load when empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_kind <= ld_kind;
            r_out_seq  <= ld_seq;
            r_out_pay  <= ld_pay;
            r_out_fin  <= ld_fin;
            r_out_oc   <= ld_oc;
            r_out_last <= ld_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.out_seq     = r_out_seq;
    assign o_res.out_payload = r_out_pay;
    assign o_res.out_final   = r_out_fin;
    assign o_res.outcome     = r_out_oc;
    assign o_res.last        = r_out_last;

`ifndef SYNTHESIS
    // An accepted packet drops input ready in the cycle after the transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pkt.valid && i_pkt.ready) |=> !i_pkt.ready)
        else $error("input ready right after a transfer");

    // Every delivery advances the expected number by one
    a_exp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && (ld_kind == srr_pkg::KIND_DELIV)) |=> (r_exp == $past(r_exp) + 32'd1))
        else $error("expected number did not advance on delivery");

    // The slot of the expected number is never occupied between packets
    a_exp_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srr_pkg::S_IDLE) |-> !r_valid[r_exp_idx])
        else $error("expected slot holds a packet while idle");

    // Only an in-order acknowledgment is followed by deliveries
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == srr_pkg::KIND_ACK) && !r_out_last)
            |-> (r_out_oc == srr_pkg::OC_INORDER))
        else $error("non-final acknowledgment for a packet not in order");
`endif

endmodule
